// ===== design/gsfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gsfr_pkg;

	localparam int unsigned ByteW    = 8;
	localparam int unsigned StatusW  = 2;
	localparam int unsigned ReadingW = 16;
	localparam int unsigned PosW     = 4;
	localparam int unsigned SumW     = 16;

	// tdata widths, padded to whole bytes
	localparam int unsigned InDataW  = 8;
	localparam int unsigned OutDataW = 24;

	localparam logic [ByteW-1:0] HdrFirst  = 8'h42;
	localparam logic [ByteW-1:0] HdrSecond = 8'h4D;
	localparam logic [ByteW-1:0] LenExpect = 8'h08;

	// frame byte positions
	localparam logic [PosW-1:0] PosAfterHdr = 4'd2;
	localparam logic [PosW-1:0] PosLength   = 4'd3;
	localparam logic [PosW-1:0] PosValHigh  = 4'd4;
	localparam logic [PosW-1:0] PosValLow   = 4'd5;
	localparam logic [PosW-1:0] PosLastSum  = 4'd9;
	localparam logic [PosW-1:0] PosSumHigh  = 4'd10;
	localparam logic [PosW-1:0] PosFinal    = 4'd11;

	typedef enum logic [StatusW-1:0] {
		ST_OK     = 2'd0,
		ST_BADLEN = 2'd1,
		ST_BADSUM = 2'd2
	} frame_status_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'b001,
		PH_GOT42   = 3'b010,
		PH_COLLECT = 3'b100
	} phase_t;

	typedef struct packed {
		frame_status_t         frame_status;
		logic [ReadingW-1:0]   gas_reading;
	} result_t;

endpackage

`default_nettype wire

// ===== design/gsfr_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gsfr_in_stage
	import gsfr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [ByteW-1:0] s_tdata,
	output logic                  byte_valid,
	output logic [ByteW-1:0]      byte_data,
	input  wire logic             byte_take
);

	logic             valid_s1;
	logic [ByteW-1:0] data_s1;

	assign s_tready   = !valid_s1 || byte_take;
	assign byte_valid = valid_s1;
	assign byte_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
		end
	end

endmodule

`default_nettype wire

// ===== design/gsfr_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gsfr_parser
	import gsfr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             byte_valid,
	input  wire logic [ByteW-1:0] byte_data,
	output logic                  byte_take,
	input  wire logic             res_space,
	output logic                  res_valid,
	output result_t               res
);

	phase_t                phase_q;
	logic [PosW-1:0]       pos_q;
	logic [SumW-1:0]       sum_q;
	logic [ByteW-1:0]      len_q;
	logic [ByteW-1:0]      val_hi_q;
	logic [ByteW-1:0]      val_lo_q;
	logic [ByteW-1:0]      sum_hi_q;
	logic [ReadingW-1:0]   held_q;

	logic          is_final;
	logic          sum_ok;
	frame_status_t status;

	// positions beyond the last byte are treated as the last byte
	assign is_final  = (phase_q == PH_COLLECT) && (pos_q >= PosFinal);
	assign byte_take = byte_valid && (!is_final || res_space);
	assign res_valid = byte_take && is_final;

	assign sum_ok = (sum_q[SumW-1 -: ByteW] == sum_hi_q) && (sum_q[ByteW-1:0] == byte_data);

	always_comb begin
		if (len_q != LenExpect) begin
			status = ST_BADLEN;
		end else if (!sum_ok) begin
			status = ST_BADSUM;
		end else begin
			status = ST_OK;
		end
	end

	assign res.frame_status = status;
	assign res.gas_reading  = (status == ST_OK) ? {val_hi_q, val_lo_q} : held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pos_q    <= '0;
			sum_q    <= '0;
			len_q    <= '0;
			val_hi_q <= '0;
			val_lo_q <= '0;
			sum_hi_q <= '0;
			held_q   <= '0;
		end else if (byte_take) begin
			case (phase_q)
				PH_GOT42: begin
					if (byte_data == HdrSecond) begin
						phase_q <= PH_COLLECT;
						pos_q   <= PosAfterHdr;
						sum_q   <= SumW'(HdrFirst) + SumW'(HdrSecond);
					end else begin
						phase_q <= PH_IDLE;
					end
				end
				PH_COLLECT: begin
					if (is_final) begin
						if (status == ST_OK) begin
							held_q <= {val_hi_q, val_lo_q};
						end
						phase_q <= PH_IDLE;
						pos_q   <= '0;
					end else begin
						if (pos_q <= PosLastSum) begin
							sum_q <= sum_q + SumW'(byte_data);
						end
						if (pos_q == PosLength) begin
							len_q <= byte_data;
						end else if (pos_q == PosValHigh) begin
							val_hi_q <= byte_data;
						end else if (pos_q == PosValLow) begin
							val_lo_q <= byte_data;
						end else if (pos_q == PosSumHigh) begin
							sum_hi_q <= byte_data;
						end
						pos_q <= pos_q + 1'b1;
					end
				end
				default: begin
					phase_q <= (byte_data == HdrFirst) ? PH_GOT42 : PH_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_res_only_collect: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (phase_q == PH_COLLECT))
		else $error("result outside frame collection");

	a_rearm_after_res: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> (phase_q == PH_IDLE) && (pos_q == '0))
		else $error("parser did not rearm after frame");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_COLLECT) |-> (pos_q >= PosAfterHdr) && (pos_q <= PosFinal))
		else $error("frame position out of range");

	a_no_take_without_space: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_valid && is_final && !res_space) |=> $stable(phase_q) && $stable(held_q))
		else $error("final byte consumed while result slot full");
`endif

endmodule

`default_nettype wire

// ===== design/gsfr_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gsfr_out_stage
	import gsfr_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                res_valid,
	input  wire result_t             res,
	output logic                     res_space,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [OutDataW-1:0]      m_tdata
);

	logic    valid_q;
	result_t res_q;

	assign res_space = !valid_q || m_tready;
	assign m_tvalid  = valid_q;
	assign m_tdata   = {(OutDataW - StatusW - ReadingW)'(0), res_q.gas_reading,
		res_q.frame_status};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_space) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_space && res_valid) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== design/gas_sensor_frame_receiver_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   s_tdata[7:0]  rx_byte
// m_*       out  m_tvalid/m_tready   m_tdata[1:0] frame_status, [17:2] gas_reading
//
// takes one byte per cycle unless the final byte stalls; one word out per complete frame
// a byte passes the input register, then the parser into the result register
// arst_n clears the valid flags, the hunt state, the running sum and the held reading
// a full result register stalls only the final byte of a frame; other bytes keep flowing
// m_tready low never drops or repeats a word

module gas_sensor_frame_receiver_top
	import gsfr_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [InDataW-1:0]  s_tdata,   // [7:0] rx_byte
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [OutDataW-1:0]      m_tdata    // [1:0] frame_status, [17:2] gas_reading, rest 0
);

	// input register to parser
	logic             byte_valid;
	logic [ByteW-1:0] byte_data;
	logic             byte_take;

	// parser to result register
	logic    res_valid;
	logic    res_space;
	result_t res;

	// byte capture stage, frees the upstream side while a word waits downstream
	gsfr_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata[ByteW-1:0]),
		.byte_valid (byte_valid),
		.byte_data  (byte_data),
		.byte_take  (byte_take)
	);

	// header hunt, frame collection, length and checksum check
	gsfr_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_data  (byte_data),
		.byte_take  (byte_take),
		.res_space  (res_space),
		.res_valid  (res_valid),
		.res        (res)
	);

	// result register toward the downstream side
	gsfr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_space (res_space),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire

// ===== dv/tb_gas_sensor_frame_receiver_top.sv =====
`timescale 1ns / 1ps

module tb_gas_sensor_frame_receiver_top;
	import gsfr_pkg::*;

	// run shape
	localparam int DirLen      = 27;
	localparam int ItemTarget  = 950;
	localparam int HoldCycles  = 400;   // long output back-pressure stretch
	localparam int QuietLimit  = 2000;  // cycles with no word moving on either side
	localparam int DrainCycles = 16;    // idle slack after the last report comes out
	localparam int FrameLen    = 12;

	typedef enum int {
		FRM_GOOD,
		FRM_BADLEN,
		FRM_BADSUM
	} frame_kind_t;

	// one directed word, with a hand-written report where it is obvious
	typedef struct packed {
		logic [ByteW-1:0]    rx;
		logic                has_report;
		frame_status_t       status;
		logic [ReadingW-1:0] reading;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;   // [7:0] rx_byte
	logic                m_tvalid;
	logic                m_tready;
	logic [OutDataW-1:0] m_tdata;   // [1:0] frame_status, [17:2] gas_reading, rest 0

	gas_sensor_frame_receiver_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// ---------------------------------------------------------------
	// shadow parser state
	// ---------------------------------------------------------------
	phase_t              hunt_phase;
	logic [PosW-1:0]     frm_pos;
	logic [SumW-1:0]     frm_sum;
	logic [ByteW-1:0]    len_byte;
	logic [ByteW-1:0]    val_hi;
	logic [ByteW-1:0]    val_lo;
	logic [ByteW-1:0]    sum_hi;
	logic [ReadingW-1:0] reading_held;

	result_t pending_reports[$];   // frame reports still owed by the block

	dir_row_t dir_rows [0:DirLen-1];

	int err_cnt;
	int bytes_in;
	int frame_bytes;
	int frames_sent;
	int burst_left;
	int quiet_cycles;
	int holds_done;
	int drains_done;
	int reports_ok;
	int reports_badlen;
	int reports_badsum;
	bit hold_req;
	int rx_mode;
	int rx_tick;

	// advance the shadow parser by one received byte; returns 1 when a frame report falls out
	function automatic bit predict_frame_byte(input logic [ByteW-1:0] b, output result_t rep);
		frame_status_t st;
		rep = '0;
		if (hunt_phase == PH_GOT42) begin
			// a second 0x42 is not a fresh start, it just drops the hunt
			if (b == HdrSecond) begin
				hunt_phase = PH_COLLECT;
				frm_pos    = PosAfterHdr;
				frm_sum    = {8'h00, HdrFirst} + {8'h00, HdrSecond};
			end else begin
				hunt_phase = PH_IDLE;
			end
			return 1'b0;
		end
		if (hunt_phase != PH_COLLECT) begin
			hunt_phase = (b == HdrFirst) ? PH_GOT42 : PH_IDLE;
			return 1'b0;
		end
		if (frm_pos < PosFinal) begin
			if (frm_pos <= PosLastSum)
				frm_sum = frm_sum + {8'h00, b};
			case (frm_pos)
				PosLength:  len_byte = b;
				PosValHigh: val_hi   = b;
				PosValLow:  val_lo   = b;
				PosSumHigh: sum_hi   = b;
				default: ;
			endcase
			frm_pos = frm_pos + 1'b1;
			return 1'b0;
		end
		// checksum low byte closes the frame; a bad length wins over a bad sum
		if (len_byte != LenExpect) begin
			st = ST_BADLEN;
		end else if (frm_sum[15:8] != sum_hi || frm_sum[7:0] != b) begin
			st = ST_BADSUM;
		end else begin
			st = ST_OK;
			reading_held = {val_hi, val_lo};
		end
		hunt_phase       = PH_IDLE;
		frm_pos          = '0;
		rep.frame_status = st;
		rep.gas_reading  = reading_held;
		return 1'b1;
	endfunction

	// bytes biased toward the extremes and the header values
	function automatic logic [ByteW-1:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return HdrFirst;
			3: return HdrSecond;
			default: return 8'($urandom);
		endcase
	endfunction

	// ---------------------------------------------------------------
	// clock and output checking
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// every accepted word is matched against the oldest owed report
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				$error("unexpected word on output: tdata 0x%06h", m_tdata);
				err_cnt++;
			end else begin
				want = pending_reports.pop_front();
				if (m_tdata[1:0] != want.frame_status) begin
					$error("frame_status: expected %0d, actual %0d",
						want.frame_status, m_tdata[1:0]);
					err_cnt++;
				end
				if (m_tdata[17:2] != want.gas_reading) begin
					$error("gas_reading: expected 0x%04h, actual 0x%04h",
						want.gas_reading, m_tdata[17:2]);
					err_cnt++;
				end
				if (m_tdata[OutDataW-1:18] != '0) begin
					$error("tdata padding: expected 0x0, actual 0x%0h",
						m_tdata[OutDataW-1:18]);
					err_cnt++;
				end
				case (want.frame_status)
					ST_OK:     reports_ok++;
					ST_BADLEN: reports_badlen++;
					default:   reports_badsum++;
				endcase
			end
		end
	end

	// watchdog: a long stretch with no word moving anywhere means the block hung
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QuietLimit) begin
			$display("timeout: no word moved for %0d cycles", QuietLimit);
			$display("Regression FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// receiver side: switches between randomly chosen stall patterns,
	// and on request holds tready low for a long counted stretch
	// ---------------------------------------------------------------
	initial begin
		m_tready = 1'b0;
		rx_mode  = 0;
		rx_tick  = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_req = 1'b0;
				holds_done++;
			end else begin
				rx_tick++;
				if (rx_tick % 64 == 0)
					rx_mode = $urandom_range(0, 3);
				case (rx_mode)
					0: m_tready <= 1'b1;                      // no stalls at all
					1: m_tready <= 1'($urandom_range(0, 1));  // coin toss
					2: m_tready <= (rx_tick % 5 == 0);        // ready when the tick count is a multiple of five
					default: m_tready <= rx_tick[3];          // follows bit 3 of the tick count
				endcase
			end
		end
	end

	// ---------------------------------------------------------------
	// sender side
	// ---------------------------------------------------------------

	// offer one word, in bursts with random gaps, and book what it should cause
	task automatic put_byte(input logic [ByteW-1:0] b, input bit typed, input result_t typed_rep);
		result_t rep;
		bit      has_rep;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				s_tdata  <= 8'($urandom);   // junk while idle must be ignored
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		bytes_in++;
		has_rep = predict_frame_byte(b, rep);
		if (typed)
			pending_reports.push_back(typed_rep);
		else if (has_rep)
			pending_reports.push_back(rep);
	endtask

	// build and send one 12-byte frame of the given kind with random payload
	task automatic send_frame(input frame_kind_t kind);
		logic [ByteW-1:0] fb [0:FrameLen-1];
		logic [SumW-1:0]  sum;
		logic [ByteW-1:0] flip;
		fb[0] = HdrFirst;
		fb[1] = HdrSecond;
		for (int i = 2; i < FrameLen; i++)
			fb[i] = pick_byte();
		fb[PosLength] = LenExpect;
		if (kind == FRM_BADLEN) begin
			flip = 8'($urandom_range(1, 255));
			fb[PosLength] = LenExpect ^ flip;
		end
		sum = '0;
		for (int i = 0; i <= PosLastSum; i++)
			sum = sum + {8'h00, fb[i]};
		// bad-length frames carry a correct checksum about half the time
		if (kind != FRM_BADLEN || $urandom_range(0, 1) == 0) begin
			fb[PosSumHigh] = sum[15:8];
			fb[PosFinal]   = sum[7:0];
		end
		if (kind == FRM_BADSUM) begin
			case ($urandom_range(0, 2))
				0: fb[PosSumHigh] ^= 8'($urandom_range(1, 255));
				1: fb[PosFinal]   ^= 8'($urandom_range(1, 255));
				default: begin
					fb[PosSumHigh] ^= 8'($urandom_range(1, 255));
					fb[PosFinal]   ^= 8'($urandom_range(1, 255));
				end
			endcase
		end
		for (int i = 0; i < FrameLen; i++)
			put_byte(fb[i], 1'b0, '0);
	endtask

	// line noise and broken headers between frames
	task automatic send_noise();
		logic [ByteW-1:0] b;
		case ($urandom_range(0, 2))
			0: begin
				repeat ($urandom_range(1, 4)) begin
					b = 8'($urandom);
					if (b == HdrFirst)
						b = 8'h00;
					put_byte(b, 1'b0, '0);
				end
			end
			1: begin
				// header start followed by anything but the second header byte
				b = pick_byte();
				if (b == HdrSecond)
					b = ~b;
				put_byte(HdrFirst, 1'b0, '0);
				put_byte(b, 1'b0, '0);
			end
			default: begin
				// repeated first header byte must not resync on the next 0x4d
				put_byte(HdrFirst, 1'b0, '0);
				put_byte(HdrFirst, 1'b0, '0);
				put_byte(HdrSecond, 1'b0, '0);
			end
		endcase
	endtask

	// stop offering until every owed report has come out
	task automatic wait_reports_done();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_reports.size() != 0);
		drains_done++;
	endtask

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		frame_kind_t kind;
		result_t     typed_rep;
		int          pick;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		err_cnt  = 0;
		bytes_in = 0;
		frame_bytes    = 0;
		frames_sent    = 0;
		burst_left     = 0;
		quiet_cycles   = 0;
		holds_done     = 0;
		drains_done    = 0;
		reports_ok     = 0;
		reports_badlen = 0;
		reports_badsum = 0;
		hold_req       = 1'b0;

		hunt_phase   = PH_IDLE;
		frm_pos      = '0;
		frm_sum      = '0;
		len_byte     = '0;
		val_hi       = '0;
		val_lo       = '0;
		sum_hi       = '0;
		reading_held = '0;

		// directed words: broken header, a bad-length frame straight after reset
		// (reading still zero), then a valid frame carrying the largest reading
		dir_rows = '{
			'{8'h42, 1'b0, ST_OK,     16'h0000},   // first header byte
			'{8'h42, 1'b0, ST_OK,     16'h0000},   // repeated, drops to idle
			'{8'h4D, 1'b0, ST_OK,     16'h0000},   // no resync here
			'{8'h42, 1'b0, ST_OK,     16'h0000},
			'{8'h4D, 1'b0, ST_OK,     16'h0000},
			'{8'hFF, 1'b0, ST_OK,     16'h0000},
			'{8'hFF, 1'b0, ST_OK,     16'h0000},   // length 0xff
			'{8'h00, 1'b0, ST_OK,     16'h0000},
			'{8'h00, 1'b0, ST_OK,     16'h0000},
			'{8'hFF, 1'b0, ST_OK,     16'h0000},
			'{8'hFF, 1'b0, ST_OK,     16'h0000},
			'{8'hFF, 1'b0, ST_OK,     16'h0000},
			'{8'hFF, 1'b0, ST_OK,     16'h0000},
			'{8'h00, 1'b0, ST_OK,     16'h0000},   // sum also wrong
			'{8'h00, 1'b1, ST_BADLEN, 16'h0000},   // length wins, reading after reset
			'{8'h42, 1'b0, ST_OK,     16'h0000},
			'{8'h4D, 1'b0, ST_OK,     16'h0000},
			'{8'h00, 1'b0, ST_OK,     16'h0000},
			'{8'h08, 1'b0, ST_OK,     16'h0000},
			'{8'hFF, 1'b0, ST_OK,     16'h0000},
			'{8'hFF, 1'b0, ST_OK,     16'h0000},
			'{8'h00, 1'b0, ST_OK,     16'h0000},
			'{8'h00, 1'b0, ST_OK,     16'h0000},
			'{8'h00, 1'b0, ST_OK,     16'h0000},
			'{8'h00, 1'b0, ST_OK,     16'h0000},
			'{8'h02, 1'b0, ST_OK,     16'h0000},   // sum 0x0295
			'{8'h95, 1'b1, ST_OK,     16'hFFFF}    // valid, top reading
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DirLen; i++) begin
			typed_rep.frame_status = dir_rows[i].status;
			typed_rep.gas_reading  = dir_rows[i].reading;
			put_byte(dir_rows[i].rx, dir_rows[i].has_report, typed_rep);
		end
		wait_reports_done();

		// random frames, mostly well formed, with noise and broken headers between
		while (frame_bytes < ItemTarget - DirLen) begin
			if ($urandom_range(0, 3) == 0)
				send_noise();
			pick = $urandom_range(0, 9);
			if (pick < 6)
				kind = FRM_GOOD;
			else if (pick < 8)
				kind = FRM_BADLEN;
			else
				kind = FRM_BADSUM;
			send_frame(kind);
			frame_bytes += FrameLen;
			frames_sent++;
			// long output hold while frames keep coming: fills the block, stalls input
			if (frames_sent == 15 || frames_sent == 50)
				hold_req = 1'b1;
			if (frames_sent == 30 || $urandom_range(0, 24) == 0)
				wait_reports_done();
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_reports.size() != 0);
		repeat (DrainCycles) @(posedge clk);

		$display("covered %0d input words in %0d random frames plus directed ones",
			bytes_in, frames_sent);
		$display("reports checked: ok %0d, bad length %0d, bad checksum %0d; %0d holds, %0d drains",
			reports_ok, reports_badlen, reports_badsum, holds_done, drains_done);
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/gsfr_pkg.sv
design/gsfr_in_stage.sv
design/gsfr_parser.sv
design/gsfr_out_stage.sv
design/gas_sensor_frame_receiver_top.sv
dv/tb_gas_sensor_frame_receiver_top.sv
